/* rtl/core/direct_form_fir_filter_top_macros.svh */
// Assertion macros used by the filter sequencer.
// Define NO_ASSERTIONS to compile them out.
`ifndef DIRECT_FORM_FIR_FILTER_TOP_MACROS_SVH
`define DIRECT_FORM_FIR_FILTER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define DFFIR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define DFFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DFFIR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define DFFIR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/dffir_pkg.sv */
`timescale 1ns / 1ps

package dffir_pkg;

    // Fixed field widths
    localparam int TAP_CNT_W  = 7;
    localparam int COEF_IDX_W = 6;

    // Item kind codes (carried on tuser)
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_WAIT
    } t_state;

    // Sequencer to MAC control
    typedef struct packed {
        logic start;   // clear accumulator, new sample item
        logic issue;   // tap read issued this cycle
        logic last;    // this read is the final tap
    } t_mac_ctl;

    // MAC to sequencer status
    typedef struct packed {
        logic done;    // result moved into the output register
    } t_mac_status;

endpackage

/* rtl/core/dffir_store.sv */
`timescale 1ns / 1ps

module dffir_store #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = 6
) (
    input  logic                    i_clk,
    input  logic                    i_coef_we,
    input  logic [AW-1:0]           i_coef_wa,
    input  logic [SAMPLE_WIDTH-1:0] i_coef_wd,
    input  logic [AW-1:0]           i_coef_ra,
    output logic [SAMPLE_WIDTH-1:0] o_coef_rd,
    input  logic                    i_hist_we,
    input  logic [AW-1:0]           i_hist_wa,
    input  logic [SAMPLE_WIDTH-1:0] i_hist_wd,
    input  logic [AW-1:0]           i_hist_ra,
    output logic [SAMPLE_WIDTH-1:0] o_hist_rd
);

    logic [SAMPLE_WIDTH-1:0] r_coef_mem [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] r_hist_mem [MAX_TAPS];
    logic [SAMPLE_WIDTH-1:0] r_coef_rd;
    logic [SAMPLE_WIDTH-1:0] r_hist_rd;

    // Coefficient store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_coef_we) begin
            r_coef_mem[i_coef_wa] <= i_coef_wd;
        end
        r_coef_rd <= r_coef_mem[i_coef_ra];
    end

    // Sample history ring: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_hist_we) begin
            r_hist_mem[i_hist_wa] <= i_hist_wd;
        end
        r_hist_rd <= r_hist_mem[i_hist_ra];
    end

    assign o_coef_rd = r_coef_rd;
    assign o_hist_rd = r_hist_rd;

endmodule

/* rtl/core/dffir_mac.sv */
`timescale 1ns / 1ps

module dffir_mac #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dffir_pkg::t_mac_ctl      i_ctl,
    output dffir_pkg::t_mac_status   o_status,
    input  logic [SAMPLE_WIDTH-1:0]  i_hist_rd,
    input  logic [SAMPLE_WIDTH-1:0]  i_coef_rd,
    input  logic                     i_out_ready,
    output logic                     o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]  o_sample_out,
    output logic                     o_saturated
);

    import dffir_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = 2 * SW;
    localparam int ACC_W = PW + $clog2(MAX_TAPS) + 1;
    localparam int UPW   = ACC_W - SW + 1;

    localparam logic [ACC_W-1:0] HALF_LSB = ACC_W'(1) << (SW - 2);
    localparam logic [SW-1:0]    MAX_VAL  = {1'b0, {(SW - 1){1'b1}}};
    localparam logic [SW-1:0]    MIN_VAL  = {1'b1, {(SW - 1){1'b0}}};

    logic                    r_p1_v;
    logic                    r_p1_last;
    logic                    r_p2_v;
    logic                    r_p2_last;
    logic signed [PW-1:0]    r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_fin_pend;
    logic                    r_out_valid;
    logic [SW-1:0]           r_out_data;
    logic                    r_out_sat;

    logic                    load;
    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-1:0] shifted;
    logic [UPW-1:0]          upper;
    logic                    fits;
    logic [SW-1:0]           res_data;

    // Result moves out once the output register is free
    assign load = r_fin_pend && (!r_out_valid || i_out_ready);

    // Round half up to Q1.15, then saturate
    always_comb begin
        rounded  = r_acc + $signed(HALF_LSB);
        shifted  = rounded >>> (SW - 1);
        upper    = shifted[ACC_W-1:SW-1];
        fits     = (&upper) || !(|upper);
        res_data = fits ? shifted[SW-1:0] : (shifted[ACC_W-1] ? MIN_VAL : MAX_VAL);
    end

    // Control pipeline: read -> multiply -> accumulate -> output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v      <= 1'b0;
            r_p1_last   <= 1'b0;
            r_p2_v      <= 1'b0;
            r_p2_last   <= 1'b0;
            r_fin_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_p1_v    <= i_ctl.issue;
            r_p1_last <= i_ctl.issue && i_ctl.last;
            r_p2_v    <= r_p1_v;
            r_p2_last <= r_p1_last;
            if (r_p2_v && r_p2_last) begin
                r_fin_pend <= 1'b1;
            end else if (load) begin
                r_fin_pend <= 1'b0;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Shared multiplier and accumulator
    always_ff @(posedge i_clk) begin
        if (r_p1_v) begin
            r_prod <= $signed(i_hist_rd) * $signed(i_coef_rd);
        end
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_p2_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (load) begin
            r_out_data <= res_data;
            r_out_sat  <= !fits;
        end
    end

    assign o_status.done = load;
    assign o_out_valid   = r_out_valid;
    assign o_sample_out  = r_out_data;
    assign o_saturated   = r_out_sat;

endmodule

/* rtl/core/dffir_seq.sv */
`timescale 1ns / 1ps

`include "direct_form_fir_filter_top_macros.svh"

module dffir_seq #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16,
    parameter int AW           = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input beats
    input  logic                              i_s_valid,
    output logic                              o_s_ready,
    input  logic                              i_kind,
    input  logic [SAMPLE_WIDTH-1:0]           i_sample,
    input  logic [dffir_pkg::COEF_IDX_W-1:0]  i_coef_idx,
    input  logic [SAMPLE_WIDTH-1:0]           i_coef_val,
    // tap count register
    input  logic                              i_cfg_valid,
    input  logic [dffir_pkg::TAP_CNT_W-1:0]   i_cfg_data,
    // store ports
    output logic                              o_coef_we,
    output logic [AW-1:0]                     o_coef_wa,
    output logic [SAMPLE_WIDTH-1:0]           o_coef_wd,
    output logic [AW-1:0]                     o_coef_ra,
    output logic                              o_hist_we,
    output logic [AW-1:0]                     o_hist_wa,
    output logic [SAMPLE_WIDTH-1:0]           o_hist_wd,
    output logic [AW-1:0]                     o_hist_ra,
    // MAC
    output dffir_pkg::t_mac_ctl               o_mac_ctl,
    input  dffir_pkg::t_mac_status            i_status
);

    import dffir_pkg::*;

    localparam int TAP_W  = $clog2(MAX_TAPS + 1);
    localparam int CMP_W  = (TAP_W > TAP_CNT_W) ? TAP_W : TAP_CNT_W;
    localparam int IDX_XW = (AW + 1 > COEF_IDX_W) ? AW + 1 : COEF_IDX_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_TAPS - 1);

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [AW-1:0]        r_head, n_head;
    logic [AW-1:0]        r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]        r_tap_idx, n_tap_idx;
    logic [AW-1:0]        r_last_idx, n_last_idx;
    logic [TAP_CNT_W-1:0] r_tap_count;

    logic                 in_fire;
    logic                 is_last;
    logic [CMP_W-1:0]     tc_ext;
    logic [CMP_W-1:0]     taps_c;
    logic [IDX_XW-1:0]    idx_ext;
    logic                 idx_ok;

    // Effective tap count, clamped to two .. MAX_TAPS
    always_comb begin
        tc_ext = CMP_W'(r_tap_count);
        if (tc_ext < CMP_W'(2)) begin
            taps_c = CMP_W'(2);
        end else if (tc_ext > CMP_W'(MAX_TAPS)) begin
            taps_c = CMP_W'(MAX_TAPS);
        end else begin
            taps_c = tc_ext;
        end
    end

    assign idx_ext = IDX_XW'(i_coef_idx);
    assign idx_ok  = idx_ext < IDX_XW'(MAX_TAPS);
    assign in_fire = i_s_valid && o_s_ready;
    assign is_last = r_tap_idx == r_last_idx;

    // Tap count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TAP_CNT_W'(64);
        end else if (i_cfg_valid) begin
            r_tap_count <= i_cfg_data;
        end
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_head     <= '0;
            r_rd_ptr   <= '0;
            r_tap_idx  <= '0;
            r_last_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_head     <= n_head;
            r_rd_ptr   <= n_rd_ptr;
            r_tap_idx  <= n_tap_idx;
            r_last_idx <= n_last_idx;
        end
    end

    // Next state, store and MAC controls
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_head     = r_head;
        n_rd_ptr   = r_rd_ptr;
        n_tap_idx  = r_tap_idx;
        n_last_idx = r_last_idx;
        o_s_ready  = 1'b0;
        o_coef_we  = 1'b0;
        o_coef_wa  = idx_ext[AW-1:0];
        o_coef_wd  = i_coef_val;
        o_hist_we  = 1'b0;
        o_hist_wa  = r_head;
        o_hist_wd  = i_sample;
        o_coef_ra  = r_tap_idx;
        o_hist_ra  = r_rd_ptr;
        o_mac_ctl  = '0;

        unique case (r_state)
            S_CLEAR: begin
                // zero both stores, one entry per cycle
                o_coef_we  = 1'b1;
                o_coef_wa  = r_clr_addr;
                o_coef_wd  = '0;
                o_hist_we  = 1'b1;
                o_hist_wa  = r_clr_addr;
                o_hist_wd  = '0;
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_ready = 1'b1;
                if (in_fire) begin
                    if (i_kind == KIND_LOAD) begin
                        o_coef_we = idx_ok;
                    end else begin
                        // newest sample lands at head, tap 0 reads it back
                        o_hist_we       = 1'b1;
                        o_mac_ctl.start = 1'b1;
                        n_rd_ptr        = r_head;
                        n_tap_idx       = '0;
                        n_last_idx      = AW'(taps_c - CMP_W'(1));
                        n_state         = S_RUN;
                    end
                end
            end
            S_RUN: begin
                o_mac_ctl.issue = 1'b1;
                o_mac_ctl.last  = is_last;
                n_tap_idx       = r_tap_idx + AW'(1);
                n_rd_ptr        = (r_rd_ptr == '0) ? LAST_ADDR : r_rd_ptr - AW'(1);
                if (is_last) begin
                    n_head  = (r_head == LAST_ADDR) ? '0 : r_head + AW'(1);
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (i_status.done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `DFFIR_ASSERT_IMPL(a_tap_range, i_clk, i_rst_n, r_state == S_RUN, r_tap_idx <= r_last_idx, "tap index ran past the last tap")
    `DFFIR_ASSERT_IMPL(a_done_in_wait, i_clk, i_rst_n, i_status.done, r_state == S_WAIT, "result finished outside wait state")
    `DFFIR_ASSERT_NEXT(a_last_to_wait, i_clk, i_rst_n, o_mac_ctl.last, r_state == S_WAIT, "last tap not followed by wait")
    `DFFIR_ASSERT_NEXT(a_start_at_head, i_clk, i_rst_n, o_mac_ctl.start, r_state == S_RUN && r_rd_ptr == $past(r_head), "tap walk did not start at newest sample")

endmodule

/* rtl/core/direct_form_fir_filter_top.sv */
`timescale 1ns / 1ps

// Direct-form FIR filter, Q1.15 samples and taps, one shared multiply-accumulate.
// Input channel s_axis: tuser selects the beat kind. A load beat writes one
// coefficient. A sample beat produces one m_axis beat.
// A sample beat walks tap_count taps on the shared multiplier, tap_count being
// the clamped count, fed by one read port each on the coefficient and history
// memories, then passes the multiply and accumulate registers and the rounding
// on its way into the output register.
// s_axis_tready stays low while a sample is in work, so the next sample beat is
// taken only once the last result has moved into the output register.
// The output register holds a result while m_axis_tready is low; the next sample
// computes meanwhile, but its result waits until the register is taken.
// Config channel: i_cfg_data sets tap_count (clamped to 2..MAX_TAPS); write only
// while the block is idle. It is always ready.
// After reset both memories are cleared, one entry a cycle; no input beat is
// accepted during that pass. tap_count resets to 64.

module direct_form_fir_filter_top #(
    parameter int MAX_TAPS     = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // fields from bit 0: sample_in, coef_index, coef_value, zero fill
    input  logic [((2*SAMPLE_WIDTH+13)/8)*8-1:0]  s_axis_tdata,
    // fields from bit 0: kind
    input  logic                                  s_axis_tuser,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // fields from bit 0: sample_out, zero fill
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    // fields from bit 0: saturated
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dffir_pkg::TAP_CNT_W-1:0]       i_cfg_data
);

    import dffir_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int AW     = $clog2(MAX_TAPS);
    localparam int OUT_DW = ((SW + 7) / 8) * 8;

    logic [SW-1:0]         sample_in;
    logic [COEF_IDX_W-1:0] coef_index;
    logic [SW-1:0]         coef_value;

    logic                  coef_we;
    logic [AW-1:0]         coef_wa;
    logic [SW-1:0]         coef_wd;
    logic [AW-1:0]         coef_ra;
    logic [SW-1:0]         coef_rd;
    logic                  hist_we;
    logic [AW-1:0]         hist_wa;
    logic [SW-1:0]         hist_wd;
    logic [AW-1:0]         hist_ra;
    logic [SW-1:0]         hist_rd;
    t_mac_ctl              mac_ctl;
    t_mac_status           mac_status;
    logic [SW-1:0]         sample_out;

    // Unpack input beat
    assign sample_in  = s_axis_tdata[SW-1:0];
    assign coef_index = s_axis_tdata[SW+COEF_IDX_W-1:SW];
    assign coef_value = s_axis_tdata[2*SW+COEF_IDX_W-1:SW+COEF_IDX_W];

    assign o_cfg_ready = 1'b1;

    dffir_seq #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SW),
        .AW           (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .o_s_ready  (s_axis_tready),
        .i_kind     (s_axis_tuser),
        .i_sample   (sample_in),
        .i_coef_idx (coef_index),
        .i_coef_val (coef_value),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_coef_we  (coef_we),
        .o_coef_wa  (coef_wa),
        .o_coef_wd  (coef_wd),
        .o_coef_ra  (coef_ra),
        .o_hist_we  (hist_we),
        .o_hist_wa  (hist_wa),
        .o_hist_wd  (hist_wd),
        .o_hist_ra  (hist_ra),
        .o_mac_ctl  (mac_ctl),
        .i_status   (mac_status)
    );

    dffir_store #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SW),
        .AW           (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_coef_we (coef_we),
        .i_coef_wa (coef_wa),
        .i_coef_wd (coef_wd),
        .i_coef_ra (coef_ra),
        .o_coef_rd (coef_rd),
        .i_hist_we (hist_we),
        .i_hist_wa (hist_wa),
        .i_hist_wd (hist_wd),
        .i_hist_ra (hist_ra),
        .o_hist_rd (hist_rd)
    );

    dffir_mac #(
        .MAX_TAPS     (MAX_TAPS),
        .SAMPLE_WIDTH (SW)
    ) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (mac_ctl),
        .o_status     (mac_status),
        .i_hist_rd    (hist_rd),
        .i_coef_rd    (coef_rd),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_sample_out (sample_out),
        .o_saturated  (m_axis_tuser)
    );

    // Pack output beat
    assign m_axis_tdata = OUT_DW'(sample_out);

endmodule

/* tb/tb_direct_form_fir_filter_top.sv */
`timescale 1ns / 1ps

module tb_direct_form_fir_filter_top;
    import dffir_pkg::*;

    localparam int NTAPS     = 64;
    localparam int HDEPTH    = NTAPS - 1;
    localparam int SETTLE    = 80;      // longer than the sample latency at NTAPS taps
    localparam int LONG_HOLD = 400;

    // one expected output beat
    typedef struct packed {
        logic [15:0] value;
        logic        sat;
    } fir_out_t;

    // one row of the directed table
    typedef struct {
        logic        kind;
        logic [15:0] smp;
        logic [5:0]  idx;
        logic [15:0] cv;
        bit          typed;   // expected output given in the row
        logic [15:0] t_val;
        logic        t_sat;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic [39:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [TAP_CNT_W-1:0] i_cfg_data;

    // filter state as the block should hold it
    logic signed [15:0] hist_line [0:HDEPTH-1];
    logic signed [15:0] coef_store [0:NTAPS-1];
    logic [TAP_CNT_W-1:0] tap_sel;

    fir_out_t pending_outputs [$];
    int  err_cnt = 0;
    bit  idle_on;
    bit  hold_req;
    int  hold_left = 0;
    bit  hold_done = 0;
    int  rx_idle = 0;

    direct_form_fir_filter_top #(
        .MAX_TAPS     (NTAPS),
        .SAMPLE_WIDTH (16)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Directed rows: extremes, ignored fields, both saturation directions
    stim_row_t dir_tab [0:21] = '{
        '{KIND_SAMPLE, 16'h7FFF, 6'd0,  16'h0000, 1, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 1, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h0000, 6'd63, 16'hFFFF, 1, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd0,  16'h8000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 1, 16'h7FFF, 1'b1},
        '{KIND_SAMPLE, 16'h7FFF, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'hFFFF, 6'd63, 16'h7FFF, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd1,  16'h8000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd0,  16'h7FFF, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd1,  16'h7FFF, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h8000, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h0001, 6'd21, 16'h5555, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'hFFFF, 6'd42, 16'hAAAA, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h1234, 6'd2,  16'h4000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h1234, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd0,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd1,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_LOAD,   16'h0000, 6'd2,  16'h0000, 0, 16'h0000, 1'b0},
        '{KIND_SAMPLE, 16'h7FFF, 6'd0,  16'h0000, 0, 16'h0000, 1'b0}
    };

    // Filter one sample: sum of products, round half up, saturate, shift history
    function automatic fir_out_t fir_compute(logic signed [15:0] x);
        longint   acc;
        int       n;
        int       j;
        fir_out_t r;
        n = tap_sel;
        if (n < 2) n = 2;
        if (n > NTAPS) n = NTAPS;
        acc = longint'(x) * longint'(coef_store[0]);
        for (j = 1; j < n; j++)
            acc += longint'(hist_line[j-1]) * longint'(coef_store[j]);
        acc = (acc + 64'sd16384) >>> 15;
        r.sat = 1'b0;
        if (acc > 32767) begin
            acc = 32767;
            r.sat = 1'b1;
        end else if (acc < -32768) begin
            acc = -32768;
            r.sat = 1'b1;
        end
        r.value = acc[15:0];
        // whole line shifts regardless of tap count
        for (j = HDEPTH - 1; j > 0; j--)
            hist_line[j] = hist_line[j-1];
        hist_line[0] = x;
        return r;
    endfunction

    // Offer one beat, account for it at acceptance, then maybe gap
    task automatic send_item(logic kind, logic [15:0] smp, logic [5:0] idx,
                             logic [15:0] cv, bit typed, logic [15:0] t_val,
                             logic t_sat);
        fir_out_t r;
        s_axis_tdata  <= {2'b00, cv, idx, smp};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (kind == KIND_LOAD) begin
            coef_store[idx] = cv;
        end else begin
            r = fir_compute(smp);
            if (typed) begin
                r.value = t_val;
                r.sat   = t_sat;
            end
            pending_outputs.push_back(r);
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Wait for every output, then for the block to go quiet
    task automatic drain_wait();
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_taps(logic [TAP_CNT_W-1:0] v);
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        tap_sel = v;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 32)) - 16);
            default: return 16'($urandom());
        endcase
    endfunction

    // Random mix of coefficient loads and samples
    task automatic run_random(int count);
        int          k;
        logic [5:0]  idx;
        for (k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) < 3) begin
                if ($urandom_range(0, 1) == 0 && tap_sel > 2 && tap_sel <= NTAPS)
                    idx = 6'($urandom_range(0, tap_sel - 1));
                else
                    idx = 6'($urandom());
                send_item(KIND_LOAD, 16'($urandom()), idx, pick_q15(), 0, 16'h0, 1'b0);
            end else begin
                send_item(KIND_SAMPLE, pick_q15(), 6'($urandom()), 16'($urandom()),
                          0, 16'h0, 1'b0);
            end
        end
    endtask

    // Receiver: check each output beat, drive tready with bursts and one long hold
    always @(posedge i_clk) begin : rx_side
        fir_out_t exp_o;
        logic     nxt;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: unexpected output beat, actual value %h sat %b",
                         $time, m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                exp_o = pending_outputs.pop_front();
                if (m_axis_tdata[15:0] !== exp_o.value) begin
                    $display("%0t: sample_out mismatch, expected %h actual %h",
                             $time, exp_o.value, m_axis_tdata[15:0]);
                    err_cnt++;
                end
                if (m_axis_tuser !== exp_o.sat) begin
                    $display("%0t: saturated mismatch, expected %b actual %b",
                             $time, exp_o.sat, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
        nxt = 1'b1;
        if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1;
            hold_left = LONG_HOLD;
            nxt = 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle--;
            nxt = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rx_idle = $urandom_range(1, 14) - 1;
            nxt = 1'b0;
        end
        m_axis_tready <= nxt;
    end

    // Stimulus and end of run
    initial begin
        logic [TAP_CNT_W-1:0] tap_plan [0:11];
        int i;
        tap_plan = '{7'd2, 7'd0, 7'd1, 7'd127, 7'd65, 7'd64, 7'd5, 7'd33,
                     7'd0, 7'd0, 7'd0, 7'd64};
        i_rst_n       <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= KIND_LOAD;
        s_axis_tvalid <= 1'b0;
        m_axis_tready <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        idle_on       <= 1'b1;
        hold_req      <= 1'b0;
        tap_sel = 7'd64;
        for (i = 0; i < HDEPTH; i++) hist_line[i] = '0;
        for (i = 0; i < NTAPS; i++) coef_store[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part at the reset tap count
        foreach (dir_tab[i])
            send_item(dir_tab[i].kind, dir_tab[i].smp, dir_tab[i].idx, dir_tab[i].cv,
                      dir_tab[i].typed, dir_tab[i].t_val, dir_tab[i].t_sat);
        drain_wait();

        // random phases over a spread of tap counts
        for (i = 0; i < 12; i++) begin
            if (tap_plan[i] == 7'd0 && i >= 8)
                write_taps(7'($urandom_range(2, NTAPS)));
            else
                write_taps(tap_plan[i]);
            idle_on  <= (i != 6) && (i != 11);
            if (i == 0) hold_req <= 1'b1;
            run_random(110);
            drain_wait();
        end

        if (err_cnt == 0) begin
            $display("PASS direct_form_fir_filter_top");
        end else begin
            $display("FAIL direct_form_fir_filter_top");
        end
        $finish;
    end

    // Run limit
    initial begin
        #8_000_000;
        $display("FAIL direct_form_fir_filter_top");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dffir_pkg.sv
rtl/core/dffir_store.sv
rtl/core/dffir_mac.sv
rtl/core/dffir_seq.sv
rtl/core/direct_form_fir_filter_top.sv
tb/tb_direct_form_fir_filter_top.sv
